// ===== hdl/bpfr_pkg.sv =====
// ----------------------------------------------------------------------------
// bpfr_pkg
// Shared types and constants of the byte pattern find and replace unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bpfr_pkg;

   // largest find / replace pattern, in bytes
   localparam int MAX_PATTERN_DEFAULT = 8;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 64;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_LENGTH  = 2'd0,
      CSR_FIND_PATTERN    = 2'd1,
      CSR_REPLACE_PATTERN = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [3:0]  pattern_length;
      logic [63:0] find_pattern;
      logic [63:0] replace_pattern;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      pattern_length:  4'd1,
      find_pattern:    64'd0,
      replace_pattern: 64'd0
   };

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       patch_start;
      logic       out_last;
   } rsp_item_type;

   // oldest window byte handed to the output register
   typedef struct packed {
      logic         valid;
      rsp_item_type item;
   } pop_type;

endpackage

`default_nettype wire

// ===== hdl/byte_pattern_find_replace_unit.sv =====
// ----------------------------------------------------------------------------
// byte_pattern_find_replace_unit
// Streaming find and replace of a 1 to 8 byte pattern in a byte stream.
// ----------------------------------------------------------------------------
// Each accepted item is one byte of a buffer; in_last marks its final byte.
// Every non-overlapping occurrence of the find pattern, scanned left to
// right, comes out replaced by the replace pattern, and its first byte
// carries patch_start. Output lags input by pattern_length - 1 bytes.
// Sustained rate is one item per cycle in both directions: the window is
// compared against the find pattern combinationally, and one byte per cycle
// drains from the window into a single result register. An item with
// in_last releases every pending byte, so after it the input stalls while
// the window drains at one byte per cycle. After the length was lowered
// with bytes still pending, one item can release up to MAX_PATTERN bytes
// and stall the input while they drain. Result back-pressure adds its own
// stall cycles. A result appears in the cycle after the window releases it.
// Configuration must be written only while the unit is idle; the unit
// itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_pattern_find_replace_unit #(
   parameter int MAX_PATTERN = bpfr_pkg::MAX_PATTERN_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // input byte channel
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire bpfr_pkg::req_item_type            req_item,
   // result byte channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output bpfr_pkg::rsp_item_type                 rsp_item,
   // configuration writes
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [bpfr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [bpfr_pkg::CSR_DATA_W-1:0]   csr_data
);

   bpfr_pkg::cfg_type cfg;
   bpfr_pkg::pop_type pop;
   logic              slot_free;

   // pattern length and the two patterns
   bpfr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // window: append, compare, replace, release oldest bytes one per cycle while the result register is free
   bpfr_window #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .slot_free (slot_free),
      .pop       (pop)
   );

   // result register parts the window from a stalled consumer
   bpfr_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .pop       (pop),
      .slot_free (slot_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   // a released byte must never overwrite a result still waiting
   a_pop_into_free_slot : assert property (@(posedge clock) disable iff (reset)
      pop.valid |-> slot_free)
      else $error("window released a byte into an occupied result register");

   // every released byte shows up on the result channel next cycle
   a_pop_reaches_output : assert property (@(posedge clock) disable iff (reset)
      pop.valid |=> (rsp_valid && (rsp_item == $past(pop.item))))
      else $error("released byte did not reach the result register");

endmodule

`default_nettype wire

// ===== hdl/bpfr_csr.sv =====
// ----------------------------------------------------------------------------
// bpfr_csr
// Configuration registers: pattern length, find pattern, replace pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module bpfr_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [bpfr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [bpfr_pkg::CSR_DATA_W-1:0]   csr_data,
   output bpfr_pkg::cfg_type                      cfg
);

   bpfr_pkg::cfg_type cfg_ff;
   bpfr_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (bpfr_pkg::csr_index_type'(csr_index))
            bpfr_pkg::CSR_PATTERN_LENGTH:  cfg_in.pattern_length  = csr_data[3:0];
            bpfr_pkg::CSR_FIND_PATTERN:    cfg_in.find_pattern    = csr_data;
            bpfr_pkg::CSR_REPLACE_PATTERN: cfg_in.replace_pattern = csr_data;
            default: ; // unknown index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= bpfr_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/bpfr_window.sv =====
// ----------------------------------------------------------------------------
// bpfr_window
// Pending byte window with append, match, replace and in-order drain.
// ----------------------------------------------------------------------------
`default_nettype none

module bpfr_window #(
   parameter int MAX_PATTERN = bpfr_pkg::MAX_PATTERN_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire bpfr_pkg::cfg_type       cfg,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire bpfr_pkg::req_item_type  req_item,
   input  wire logic                    slot_free,
   output bpfr_pkg::pop_type            pop
);

   localparam int CNT_W = $clog2(MAX_PATTERN + 1);
   localparam int WIN_W = MAX_PATTERN * 8;

   // byte i of the window at bits 8i+7..8i, oldest at byte 0
   logic [WIN_W-1:0]       win_ff, win_in, win0, win1, win2;
   logic [MAX_PATTERN-1:0] marks_ff, marks_in, marks0, marks1, marks2;
   logic [CNT_W-1:0]       fill_ff, fill_in, fill0, fillc, fill1;
   logic [CNT_W-1:0]       prot_ff, prot_in, prot0, protc, prot2;
   // bytes already due for output, and whether they end a buffer
   logic [CNT_W-1:0]       pend_ff, pend_in, pend0;
   logic                   pend_last_ff, pend_last_in;
   logic [CNT_W-1:0]       len_eff, count;
   logic                   pop_go, hit, take;

   // effective pattern length, clamped to 1..MAX_PATTERN
   always_comb begin
      if (cfg.pattern_length == 4'd0) begin
         len_eff = CNT_W'(1);
      end else if (int'(cfg.pattern_length) > MAX_PATTERN) begin
         len_eff = CNT_W'(MAX_PATTERN);
      end else begin
         len_eff = CNT_W'(cfg.pattern_length);
      end
   end

   always_comb begin
      pop_go = (pend_ff != '0) && slot_free;
      win0   = pop_go ? (win_ff >> 8) : win_ff;
      marks0 = pop_go ? (marks_ff >> 1) : marks_ff;
      fill0  = fill_ff - CNT_W'(pop_go);
      pend0  = pend_ff - CNT_W'(pop_go);
      prot0  = (pop_go && (prot_ff != '0)) ? prot_ff - CNT_W'(1) : prot_ff;

      fillc = (fill0 >= CNT_W'(MAX_PATTERN)) ? CNT_W'(MAX_PATTERN - 1) : fill0;
      protc = (prot0 > fillc) ? fillc : prot0;

      // append the new byte
      win1   = win0;
      marks1 = marks0;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         if (CNT_W'(i) == fillc) begin
            win1[i*8 +: 8] = req_item.in_byte;
            marks1[i]      = 1'b0;
         end
      end
      fill1 = fillc + CNT_W'(1);

      // parallel compare of the oldest len bytes
      hit = (protc == '0) && (fill1 >= len_eff);
      for (int i = 0; i < MAX_PATTERN; i++) begin
         if ((CNT_W'(i) < len_eff) && (win1[i*8 +: 8] != cfg.find_pattern[i*8 +: 8])) begin
            hit = 1'b0;
         end
      end

      win2   = win1;
      marks2 = marks1;
      prot2  = protc;
      if (hit) begin
         for (int i = 0; i < MAX_PATTERN; i++) begin
            if (CNT_W'(i) < len_eff) begin
               win2[i*8 +: 8] = cfg.replace_pattern[i*8 +: 8];
            end
         end
         marks2[0] = 1'b1;
         prot2     = len_eff;
      end

      // bytes released by this item
      if (req_item.in_last) begin
         count = fill1;
      end else if (fill1 >= len_eff) begin
         count = fill1 - len_eff + CNT_W'(1);
      end else begin
         count = '0;
      end

      take = req_valid && (pend0 == '0);
      if (take) begin
         win_in       = win2;
         marks_in     = marks2;
         fill_in      = fill1;
         prot_in      = prot2;
         pend_in      = count;
         pend_last_in = req_item.in_last;
      end else begin
         win_in       = win0;
         marks_in     = marks0;
         fill_in      = fill0;
         prot_in      = prot0;
         pend_in      = pend0;
         pend_last_in = pend_last_ff;
      end
   end

   assign req_stall            = (pend0 != '0);
   assign pop.valid            = pop_go;
   assign pop.item.out_byte    = win_ff[7:0];
   assign pop.item.patch_start = marks_ff[0];
   assign pop.item.out_last    = pend_last_ff && (pend_ff == CNT_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         marks_ff     <= '0;
         fill_ff      <= '0;
         prot_ff      <= '0;
         pend_ff      <= '0;
         pend_last_ff <= 1'b0;
      end else begin
         marks_ff     <= marks_in;
         fill_ff      <= fill_in;
         prot_ff      <= prot_in;
         pend_ff      <= pend_in;
         pend_last_ff <= pend_last_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

endmodule

`default_nettype wire

// ===== hdl/bpfr_out_stage.sv =====
// ----------------------------------------------------------------------------
// bpfr_out_stage
// Result register between the window and the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module bpfr_out_stage (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire bpfr_pkg::pop_type     pop,
   output logic                       slot_free,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output bpfr_pkg::rsp_item_type     rsp_item
);

   logic                   valid_ff, valid_in;
   bpfr_pkg::rsp_item_type item_ff, item_in;

   assign slot_free = !valid_ff || !rsp_stall;
   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (slot_free) begin
         valid_in = pop.valid;
         if (pop.valid) begin
            item_in = pop.item;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the byte pattern find and replace unit.
// ----------------------------------------------------------------------------
// A directed series covers the reset configuration, the pattern length
// extremes, out of range lengths, non-overlapping matches, a length change
// with bytes still pending and a write to an unused register index. Random
// phases then stream buffers built mostly from copies and pieces of the find
// pattern under changing configurations. Every accepted item is run through
// a local model of the window; each result byte is checked field by field
// against the oldest predicted byte. The input idles and the result side stalls at random.
// ----------------------------------------------------------------------------

module tb;

   localparam int MAX_PAT      = bpfr_pkg::MAX_PATTERN_DEFAULT;
   // window drain after in_last plus the output register, with margin
   localparam int DRAIN_CYCLES = 2 * MAX_PAT + 4;
   localparam int RANDOM_ITEMS = 370;
   localparam int CYCLE_LIMIT  = 500000;
   // index with no register behind it
   localparam logic [bpfr_pkg::CSR_INDEX_W-1:0] CSR_SPARE_INDEX = 2'd3;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #2 clock = ~clock;

   // dut inputs, all known from time zero
   logic                                 req_valid = 1'b0;
   logic                                 req_stall;
   bpfr_pkg::req_item_type               req_item  = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b0;
   bpfr_pkg::rsp_item_type               rsp_item;
   logic                                 csr_valid = 1'b0;
   logic                                 csr_ready;
   logic [bpfr_pkg::CSR_INDEX_W-1:0]     csr_index = '0;
   logic [bpfr_pkg::CSR_DATA_W-1:0]      csr_data  = '0;

   byte_pattern_find_replace_unit #(
      .MAX_PATTERN (MAX_PAT)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // shadow configuration, tracks accepted csr writes
   logic [3:0]  cfg_len  = bpfr_pkg::CFG_RESET.pattern_length;
   logic [63:0] cfg_find = bpfr_pkg::CFG_RESET.find_pattern;
   logic [63:0] cfg_repl = bpfr_pkg::CFG_RESET.replace_pattern;

   // shadow window: pending bytes oldest first, their start marks,
   // fill level and how many of the oldest are already replaced
   logic [7:0]  pend_byte [MAX_PAT];
   logic        pend_mark [MAX_PAT];
   int unsigned pend_fill = 0;
   int unsigned guard_cnt = 0;

   // predicted result bytes, oldest first
   bpfr_pkg::rsp_item_type patched_q [$];
   bpfr_pkg::rsp_item_type want_item;

   int unsigned fault_count = 0;
   int unsigned cycle_count = 0;
   bit          no_gaps     = 1'b0;
   bit          no_stalls   = 1'b0;
   int unsigned hold_cnt    = 0;

   initial begin
      for (int i = 0; i < MAX_PAT; i++) begin
         pend_byte[i] = '0;
         pend_mark[i] = 1'b0;
      end
   end

   // length register as the block uses it: 0 acts as 1, above max clamps
   function automatic int unsigned active_length();
      int unsigned len;
      len = cfg_len;
      if (len == 0) len = 1;
      if (len > MAX_PAT) len = MAX_PAT;
      return len;
   endfunction

   function automatic void apply_csr(input logic [bpfr_pkg::CSR_INDEX_W-1:0] idx,
                                     input logic [63:0] data);
      case (idx)
         bpfr_pkg::CSR_PATTERN_LENGTH:  cfg_len  = data[3:0];
         bpfr_pkg::CSR_FIND_PATTERN:    cfg_find = data;
         bpfr_pkg::CSR_REPLACE_PATTERN: cfg_repl = data;
         default: ;
      endcase
   endfunction

   // one input byte through the window; queues every byte it releases
   function automatic void predict_patch(input logic [7:0] b, input logic last);
      int unsigned            len;
      int unsigned            count;
      bit                     hit;
      bpfr_pkg::rsp_item_type r;
      len = active_length();
      if (pend_fill >= MAX_PAT) pend_fill = MAX_PAT - 1;
      if (guard_cnt > pend_fill) guard_cnt = pend_fill;
      pend_byte[pend_fill] = b;
      pend_mark[pend_fill] = 1'b0;
      pend_fill++;
      // match only on unprotected bytes lying wholly inside the window
      hit = (guard_cnt == 0) && (pend_fill >= len);
      for (int i = 0; i < len; i++)
         if (pend_byte[i] != cfg_find[8*i +: 8]) hit = 1'b0;
      if (hit) begin
         for (int i = 0; i < len; i++)
            pend_byte[i] = cfg_repl[8*i +: 8];
         pend_mark[0] = 1'b1;
         guard_cnt    = len;
      end
      if (last)
         count = pend_fill;
      else if (pend_fill >= len)
         count = pend_fill - len + 1;
      else
         count = 0;
      for (int k = 0; k < count; k++) begin
         r.out_byte    = pend_byte[0];
         r.patch_start = pend_mark[0];
         r.out_last    = last && (k + 1 == count);
         patched_q.push_back(r);
         for (int i = 1; i < pend_fill; i++) begin
            pend_byte[i-1] = pend_byte[i];
            pend_mark[i-1] = pend_mark[i];
         end
         pend_fill--;
         pend_byte[pend_fill] = '0;
         pend_mark[pend_fill] = 1'b0;
         if (guard_cnt > 0) guard_cnt--;
      end
      // end of buffer clears the window
      if (last) begin
         pend_fill = 0;
         guard_cnt = 0;
         for (int i = 0; i < MAX_PAT; i++) pend_mark[i] = 1'b0;
      end
   endfunction

   // idle length: mostly none or short, now and then long
   function automatic int unsigned pick_idle();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   // cycle limit guards every wait in the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("byte_pattern_find_replace_unit: mismatch");
         $finish;
      end
   end

   // result side back-pressure: random runs of stall and flow
   always @(posedge clock) begin
      if (hold_cnt != 0) begin
         hold_cnt <= hold_cnt - 1;
      end else if (no_stalls) begin
         rsp_stall <= 1'b0;
      end else if ($urandom_range(0, 9) < 3) begin
         rsp_stall <= 1'b1;
         hold_cnt  <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                  : $urandom_range(3, 23);
      end else begin
         rsp_stall <= 1'b0;
         hold_cnt  <= $urandom_range(0, 9);
      end
   end

   // result checker against the oldest predicted byte
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (patched_q.size() == 0) begin
            $error("unexpected result item: out_byte %02h", rsp_item.out_byte);
            fault_count++;
         end else begin
            want_item = patched_q.pop_front();
            if (rsp_item.out_byte !== want_item.out_byte) begin
               $error("out_byte expected %02h actual %02h",
                      want_item.out_byte, rsp_item.out_byte);
               fault_count++;
            end
            if (rsp_item.patch_start !== want_item.patch_start) begin
               $error("patch_start expected %0b actual %0b",
                      want_item.patch_start, rsp_item.patch_start);
               fault_count++;
            end
            if (rsp_item.out_last !== want_item.out_last) begin
               $error("out_last expected %0b actual %0b",
                      want_item.out_last, rsp_item.out_last);
               fault_count++;
            end
         end
      end
   end

   // one input item; valid stays high for the caller's next item
   task automatic send_byte(input logic [7:0] b, input logic last);
      int unsigned gap;
      gap = no_gaps ? 0 : pick_idle();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= '{in_byte: b, in_last: last};
      do @(posedge clock); while (req_stall);
      predict_patch(b, last);
   endtask

   // stop input, let every predicted byte arrive, then let the window settle
   task automatic settle();
      req_valid <= 1'b0;
      while (patched_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // csr_valid is left high; the caller lowers it after its last write
   task automatic csr_write(input logic [bpfr_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [63:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      apply_csr(idx, data);
   endtask

   task automatic load_pattern(input logic [63:0] len_data,
                               input logic [63:0] find_bits,
                               input logic [63:0] repl_bits);
      settle();
      csr_write(bpfr_pkg::CSR_PATTERN_LENGTH, len_data);
      csr_write(bpfr_pkg::CSR_FIND_PATTERN, find_bits);
      csr_write(bpfr_pkg::CSR_REPLACE_PATTERN, repl_bits);
      csr_valid <= 1'b0;
   endtask

   // reset configuration: length 1, zero byte replaced by zero
   task automatic test_reset_state();
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
   endtask

   // longest pattern ending exactly on the last byte
   task automatic test_full_length();
      load_pattern(64'd8, 64'h0123_4567_89AB_CDEF, 64'hFFFF_FFFF_FFFF_FFFF);
      for (int i = 0; i < MAX_PAT; i++)
         send_byte(cfg_find[8*i +: 8], i == MAX_PAT - 1);
   endtask

   // length 0 acts as 1 (upper data bits dropped), length 15 acts as 8
   task automatic test_length_clamp();
      load_pattern(64'hFFFF_FFFF_FFFF_FFF0, 64'hA5, 64'h5A);
      send_byte(8'hA5, 1'b0);
      send_byte(8'h5A, 1'b1);
      // short tail under a full length pattern is never matched
      load_pattern(64'd15, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
   endtask

   // replaced bytes never start another match
   task automatic test_no_overlap();
      load_pattern(64'd2, 64'hAAAA, 64'hBBBB);
      send_byte(8'hAA, 1'b0);
      send_byte(8'hAA, 1'b0);
      send_byte(8'hAA, 1'b1);
   endtask

   // shorter length written while three bytes are still pending
   task automatic test_length_change_pending();
      load_pattern(64'd4, 64'h0403_0201, 64'd0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h02, 1'b0);
      send_byte(8'h03, 1'b0);
      load_pattern(64'd2, 64'h0201, 64'hEEEE);
      send_byte(8'h04, 1'b1);
   endtask

   // write to an unused index must leave the configuration alone
   task automatic test_unknown_register();
      settle();
      csr_write(CSR_SPARE_INDEX, 64'hFFFF_FFFF_FFFF_FFFF);
      csr_valid <= 1'b0;
      send_byte(8'h01, 1'b0);
      send_byte(8'h02, 1'b1);
   endtask

   // random phases of buffers built from pattern copies, prefixes and noise
   task automatic test_random_streams();
      int unsigned sent;
      int unsigned phase;
      int unsigned phase_items;
      int unsigned phase_sent;
      int unsigned buf_len;
      int unsigned eff_len;
      int unsigned kind;
      int unsigned n;
      int unsigned pick;
      bit          noise;
      logic [63:0] len_data;
      logic [63:0] find_bits;
      logic [63:0] repl_bits;
      logic [7:0]  seed_a;
      logic [7:0]  seed_b;
      logic [7:0]  chunk_q [$];
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         case (phase)
            0: begin
               len_data  = 64'd8;
               find_bits = 64'hFFFF_FFFF_FFFF_FFFF;
               repl_bits = 64'd0;
            end
            1: begin
               len_data  = 64'd1;
               find_bits = 64'd0;
               repl_bits = 64'hFFFF_FFFF_FFFF_FFFF;
            end
            default: begin
               // out of range lengths now and then, upper bits random
               len_data = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
                                                      : 64'($urandom_range(1, MAX_PAT));
               // two-symbol patterns make self-overlapping runs likely
               if ($urandom_range(0, 2) == 0) begin
                  seed_a = 8'($urandom);
                  seed_b = 8'($urandom);
                  for (int i = 0; i < MAX_PAT; i++)
                     find_bits[8*i +: 8] = $urandom_range(0, 1) ? seed_a : seed_b;
               end else begin
                  find_bits = {$urandom, $urandom};
               end
               repl_bits = ($urandom_range(0, 7) == 0) ? find_bits : {$urandom, $urandom};
            end
         endcase
         load_pattern(len_data, find_bits, repl_bits);
         no_gaps     = ($urandom_range(0, 3) == 0);
         no_stalls   = ($urandom_range(0, 3) == 0);
         eff_len     = active_length();
         phase_items = $urandom_range(15, 45);
         phase_sent  = 0;
         // a phase may end mid-buffer, leaving bytes pending for the next one
         while (phase_sent < phase_items) begin
            buf_len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3)
                                                  : $urandom_range(4, 24);
            noise   = ($urandom_range(0, 6) == 0);
            chunk_q.delete();
            while (chunk_q.size() < buf_len) begin
               kind = noise ? 6 : $urandom_range(0, 9);
               if (kind <= 3) begin
                  for (int i = 0; i < eff_len; i++)
                     chunk_q.push_back(cfg_find[8*i +: 8]);
               end else if (kind <= 5) begin
                  // broken occurrence
                  n = (eff_len > 1) ? $urandom_range(1, eff_len - 1) : 1;
                  for (int i = 0; i < n; i++)
                     chunk_q.push_back(cfg_find[8*i +: 8]);
               end else if (kind <= 7) begin
                  n = $urandom_range(1, 4);
                  for (int i = 0; i < n; i++)
                     chunk_q.push_back(8'($urandom));
               end else begin
                  // bytes drawn from the pattern itself
                  n = $urandom_range(1, 6);
                  for (int i = 0; i < n; i++) begin
                     pick = $urandom_range(0, eff_len - 1);
                     chunk_q.push_back(cfg_find[8*pick +: 8]);
                  end
               end
            end
            for (int i = 0; i < chunk_q.size() && phase_sent < phase_items; i++) begin
               send_byte(chunk_q[i], i == chunk_q.size() - 1);
               phase_sent++;
               sent++;
            end
         end
         phase++;
      end
      no_gaps   = 1'b0;
      no_stalls = 1'b0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_full_length();
      test_length_clamp();
      test_no_overlap();
      test_length_change_pending();
      test_unknown_register();
      test_random_streams();
      settle();
      if (fault_count == 0)
         $display("byte_pattern_find_replace_unit: match");
      else
         $display("byte_pattern_find_replace_unit: mismatch");
      $finish;
   end

endmodule
